// ----- rtl/nearest_palette_color_search_core_assert.svh -----
// ----------------------------------------------------------------------------
// nearest palette color search assertion macros
// shared property forms for the nearest palette search block
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_CORE_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest palette search: same-cycle check failed");

// next-cycle implication, checked outside reset
`define NPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest palette search: next-cycle check failed");

`endif

// ----- rtl/nps_pkg.sv -----
// ----------------------------------------------------------------------------
// nps_pkg
// types and constants of the nearest palette color search block
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  // payload widths
  localparam int COMP_W  = 16;
  localparam int INDEX_W = 9;
  localparam int COLOR_W = 3 * COMP_W;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int DIST_W  = SQ_W + 2;

  // default palette size
  localparam int DEFAULT_PALETTE_DEPTH = 256;

  // entry count after reset
  localparam logic [INDEX_W-1:0] ENTRY_COUNT_RESET = INDEX_W'(1);

  // request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/nearest_palette_color_search_core.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search_core
// palette store with a nearest color lookup over squared rgb distance
// ----------------------------------------------------------------------------
// A write request stores one 48-bit color at a 1-based palette position;
// positions of 0 or above the capped entry count are dropped.
// A lookup request walks entries 1 to entry_count (capped at PALETTE_DEPTH),
// reading one palette word per cycle from the single memory port into a
// pipelined distance unit (abs difference, square, sum and compare), and
// returns the 1-based index of the nearest entry, lowest index on ties.
// A lookup occupies the block for one memory read per entry, then the
// pipeline drains (read, abs difference, square, sum and compare) and the
// result is handed to the output register. An entry count of zero returns
// index 1. The input side is stalled while a lookup runs; a write
// may be taken while a finished result still waits in the output register.
// The user must write the entry count through cfg_write/cfg_data only while idle; the block does not enforce it.
// Palette contents are undefined until written; looking up unwritten
// entries gives an undefined index.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search_core #(
  parameter int PALETTE_DEPTH = nps_pkg::DEFAULT_PALETTE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // entry count register
  input  wire logic                       cfg_write,
  input  wire logic [nps_pkg::INDEX_W-1:0] cfg_data,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       req_type,
  input  wire logic [nps_pkg::INDEX_W-1:0] entry_index,
  input  wire logic [nps_pkg::COMP_W-1:0]  red,
  input  wire logic [nps_pkg::COMP_W-1:0]  green,
  input  wire logic [nps_pkg::COMP_W-1:0]  blue,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [nps_pkg::INDEX_W-1:0]     match_index
);

  // address width of the palette and width of a count that can hold the depth
  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > nps_pkg::INDEX_W) ? CNT_W : nps_pkg::INDEX_W;

  localparam int COMP_W = nps_pkg::COMP_W;
  localparam int SQ_W   = nps_pkg::SQ_W;
  localparam int DIST_W = nps_pkg::DIST_W;

  // --------------------------------------------------------------------------
  // entry count register and effective count
  // --------------------------------------------------------------------------
  logic [nps_pkg::INDEX_W-1:0] entry_count;
  logic [CMP_W-1:0]            count_wide;
  logic [CMP_W-1:0]            count_cap;
  logic [CNT_W-1:0]            count_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= nps_pkg::ENTRY_COUNT_RESET;
    end else if (cfg_write) begin
      entry_count <= cfg_data;
    end
  end

  // counts above the palette depth saturate to the depth
  assign count_wide = CMP_W'(entry_count);
  assign count_cap  = (count_wide > CMP_W'(PALETTE_DEPTH)) ? CMP_W'(PALETTE_DEPTH)
                                                           : count_wide;
  assign count_eff  = count_cap[CNT_W-1:0];

  // --------------------------------------------------------------------------
  // request decode
  // --------------------------------------------------------------------------
  nps_pkg::state_t state;
  nps_pkg::state_t state_next;

  logic             in_xfer;
  logic             wr_req;
  logic             lookup_req;
  logic [CMP_W-1:0] pos_wide;
  logic [CMP_W-1:0] pos_dec;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;

  assign in_xfer    = in_valid && !in_stall;
  assign wr_req     = in_xfer && (req_type == nps_pkg::REQ_WRITE);
  assign lookup_req = in_xfer && (req_type == nps_pkg::REQ_LOOKUP);

  // write lands only at a position from 1 to the effective count
  assign pos_wide = CMP_W'(entry_index);
  assign pos_dec  = pos_wide - CMP_W'(1);
  assign wr_en    = wr_req && (pos_wide != '0) && (pos_wide <= count_cap);
  assign wr_addr  = pos_dec[ADDR_W-1:0];

  // --------------------------------------------------------------------------
  // scan control
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] issue_cnt;
  logic             issue_en;
  logic             issue_last;
  logic             out_load;

  // squared stage of the distance unit, its last flag ends the scan
  logic             sq_valid;
  logic             sq_last;

  // lookup color, held for the whole scan
  logic [COMP_W-1:0] key_red;
  logic [COMP_W-1:0] key_green;
  logic [COMP_W-1:0] key_blue;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nps_pkg::ST_IDLE: begin
        if (lookup_req) begin
          state_next = (count_eff == '0) ? nps_pkg::ST_FINISH : nps_pkg::ST_SCAN;
        end
      end
      nps_pkg::ST_SCAN: begin
        if (sq_valid && sq_last) begin
          state_next = nps_pkg::ST_FINISH;
        end
      end
      nps_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = nps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nps_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    issue_en = 1'b0;
    out_load = 1'b0;
    case (state)
      nps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      nps_pkg::ST_SCAN: begin
        issue_en = (issue_cnt != count_eff);
      end
      nps_pkg::ST_FINISH: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign issue_last = (issue_cnt == count_eff - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
    end else if (lookup_req) begin
      issue_cnt <= '0;
    end else if (issue_en) begin
      issue_cnt <= issue_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_req) begin
      key_red   <= red;
      key_green <= green;
      key_blue  <= blue;
    end
  end

  // --------------------------------------------------------------------------
  // palette memory, one write or one registered read per cycle
  // --------------------------------------------------------------------------
  logic [nps_pkg::COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
  logic [nps_pkg::COLOR_W-1:0] rd_data;
  logic                        rd_valid;
  logic                        rd_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_mem[wr_addr] <= {red, green, blue};
    end
    if (issue_en) begin
      rd_data <= palette_mem[issue_cnt[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_valid <= issue_en;
      rd_last  <= issue_en && issue_last;
    end
  end

  // --------------------------------------------------------------------------
  // distance unit: abs difference, square, then sum and compare
  // --------------------------------------------------------------------------
  logic [COMP_W-1:0] ent_red;
  logic [COMP_W-1:0] ent_green;
  logic [COMP_W-1:0] ent_blue;
  logic [COMP_W-1:0] diff_red;
  logic [COMP_W-1:0] diff_green;
  logic [COMP_W-1:0] diff_blue;
  logic              diff_valid;
  logic              diff_last;
  logic [SQ_W-1:0]   sq_red;
  logic [SQ_W-1:0]   sq_green;
  logic [SQ_W-1:0]   sq_blue;
  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_dist;
  logic              best_empty;
  logic [CNT_W-1:0]  cmp_idx;
  logic [CNT_W-1:0]  win_idx;
  logic [CMP_W-1:0]  win_wide;

  assign ent_red   = rd_data[3*COMP_W-1:2*COMP_W];
  assign ent_green = rd_data[2*COMP_W-1:COMP_W];
  assign ent_blue  = rd_data[COMP_W-1:0];

  always_ff @(posedge clk) begin
    diff_red   <= (key_red >= ent_red) ? (key_red - ent_red) : (ent_red - key_red);
    diff_green <= (key_green >= ent_green) ? (key_green - ent_green)
                                           : (ent_green - key_green);
    diff_blue  <= (key_blue >= ent_blue) ? (key_blue - ent_blue) : (ent_blue - key_blue);
    sq_red     <= SQ_W'(diff_red) * SQ_W'(diff_red);
    sq_green   <= SQ_W'(diff_green) * SQ_W'(diff_green);
    sq_blue    <= SQ_W'(diff_blue) * SQ_W'(diff_blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      diff_last  <= 1'b0;
      sq_valid   <= 1'b0;
      sq_last    <= 1'b0;
    end else begin
      diff_valid <= rd_valid;
      diff_last  <= rd_last;
      sq_valid   <= diff_valid;
      sq_last    <= diff_last;
    end
  end

  assign dist_sum = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);

  // strict less-than keeps the lowest index on ties; the first entry always sets the initial best
  always_ff @(posedge clk) begin
    if (rst) begin
      best_empty <= 1'b1;
      cmp_idx    <= CNT_W'(1);
      win_idx    <= CNT_W'(1);
    end else if (lookup_req) begin
      best_empty <= 1'b1;
      cmp_idx    <= CNT_W'(1);
      win_idx    <= CNT_W'(1);
    end else if (sq_valid) begin
      cmp_idx <= cmp_idx + CNT_W'(1);
      if (best_empty || (dist_sum < best_dist)) begin
        best_empty <= 1'b0;
        win_idx    <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_valid && (best_empty || (dist_sum < best_dist))) begin
      best_dist <= dist_sum;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  assign win_wide = CMP_W'(win_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      match_index <= win_wide[nps_pkg::INDEX_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`include "nearest_palette_color_search_core_assert.svh"

  `NPS_ASSERT_NOW(a_pipe_only_in_scan, clk, rst,
                  rd_valid || diff_valid || sq_valid, state == nps_pkg::ST_SCAN)
  `NPS_ASSERT_NEXT(a_last_ends_scan, clk, rst,
                   (state == nps_pkg::ST_SCAN) && sq_valid && sq_last,
                   state == nps_pkg::ST_FINISH)
  `NPS_ASSERT_NOW(a_issue_bounded, clk, rst,
                  state == nps_pkg::ST_SCAN, issue_cnt <= count_eff)
  `NPS_ASSERT_NEXT(a_finish_loads_out, clk, rst,
                   out_load, out_valid && (state == nps_pkg::ST_IDLE))

endmodule

`default_nettype wire

// ----- dv/nearest_palette_color_search_checker.sv -----
// ----------------------------------------------------------------------------
// nearest palette color search checker
// watches the config port and both channels, keeps its own palette copy and
// entry count, works out the nearest entry for every lookup transfer and
// compares it with the match_index transfers in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_palette_color_search_checker #(
  parameter int PALETTE_DEPTH = nps_pkg::DEFAULT_PALETTE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [nps_pkg::INDEX_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        req_type,
  input  logic [nps_pkg::INDEX_W-1:0] entry_index,
  input  logic [nps_pkg::COMP_W-1:0]  red,
  input  logic [nps_pkg::COMP_W-1:0]  green,
  input  logic [nps_pkg::COMP_W-1:0]  blue,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [nps_pkg::INDEX_W-1:0] match_index,
  output int                          mismatches,
  output int                          awaited,
  output int                          lookups_checked,
  output int                          writes_seen
);

  localparam int INDEX_W = nps_pkg::INDEX_W;
  localparam int COMP_W  = nps_pkg::COMP_W;
  localparam int COLOR_W = nps_pkg::COLOR_W;

  logic [COLOR_W-1:0] palette_copy [PALETTE_DEPTH];
  logic [INDEX_W-1:0] entry_count_q;
  logic [INDEX_W-1:0] awaited_matches [$];

  function automatic int active_entries();
    return (entry_count_q > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(entry_count_q);
  endfunction

  function automatic logic [63:0] sq_gap(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
    logic [63:0] d;
    d = (a >= b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  // strict less-than keeps the lowest index on equal distances
  function automatic logic [INDEX_W-1:0] nearest_entry(logic [COMP_W-1:0] r,
                                                       logic [COMP_W-1:0] g,
                                                       logic [COMP_W-1:0] b);
    logic [63:0]        best;
    logic [63:0]        gap_sum;
    logic [INDEX_W-1:0] win;
    logic [COLOR_W-1:0] c;
    best = '1;
    win  = INDEX_W'(1);
    for (int i = 1; i <= active_entries(); i++) begin
      c       = palette_copy[i-1];
      gap_sum = sq_gap(r, c[3*COMP_W-1:2*COMP_W]) + sq_gap(g, c[2*COMP_W-1:COMP_W])
              + sq_gap(b, c[COMP_W-1:0]);
      if (gap_sum < best) begin
        best = gap_sum;
        win  = INDEX_W'(i);
      end
    end
    return win;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] nearest search mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic [INDEX_W-1:0] want;
    if (rst) begin
      entry_count_q = nps_pkg::ENTRY_COUNT_RESET;
      awaited_matches.delete();
      for (int i = 0; i < PALETTE_DEPTH; i++) palette_copy[i] = '0;
      mismatches      = 0;
      lookups_checked = 0;
      writes_seen     = 0;
    end else begin
      // results first, a lookup can never answer in its own cycle
      if (out_valid && !out_stall) begin
        if (awaited_matches.size() == 0) begin
          report_mismatch($sformatf("match_index %0d with no lookup outstanding",
                                    match_index));
        end else begin
          want = awaited_matches.pop_front();
          lookups_checked++;
          if (match_index !== want) begin
            report_mismatch($sformatf("match_index %0d, expected %0d", match_index, want));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (req_type == nps_pkg::REQ_WRITE) begin
          writes_seen++;
          if (entry_index != 0 && entry_index <= active_entries()) begin
            palette_copy[entry_index-1] = {red, green, blue};
          end
        end else begin
          awaited_matches.push_back(nearest_entry(red, green, blue));
        end
      end
      // a new count takes effect after this edge
      if (cfg_write) entry_count_q = cfg_data;
    end
    awaited <= awaited_matches.size();
  end

endmodule

// ----- dv/tb_nearest_palette_color_search_core.sv -----
// ----------------------------------------------------------------------------
// nearest palette color search testbench
// drives palette writes and nearest color lookups through the request channel
// under several entry counts (zero, saturated and the extremes among them),
// with random idle bursts on both channels; the checker beside the block
// predicts every match_index and the top gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_palette_color_search_core;

  localparam int INDEX_W     = nps_pkg::INDEX_W;
  localparam int COMP_W      = nps_pkg::COMP_W;
  localparam int COLOR_W     = nps_pkg::COLOR_W;
  localparam int DEPTH       = nps_pkg::DEFAULT_PALETTE_DEPTH;
  localparam int ITEM_TARGET = 1150;
  // a full 256-entry lookup, plus stall and gap bursts, must fit under this limit
  localparam int IDLE_LIMIT  = 3000;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [INDEX_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic [INDEX_W-1:0] entry_index;
  logic [COMP_W-1:0]  red;
  logic [COMP_W-1:0]  green;
  logic [COMP_W-1:0]  blue;
  logic               out_valid;
  logic               out_stall;
  logic [INDEX_W-1:0] match_index;

  int mismatches;
  int awaited;
  int lookups_checked;
  int writes_seen;

  // stimulus-side view of the palette: which entries hold a color and what
  // it is, only used to aim lookups near real entries and never read unwritten
  logic [COLOR_W-1:0] tone    [1:DEPTH];
  bit                 painted [1:DEPTH];
  int                 span;          // effective entry count
  int                 items_sent;    // transfers that change state or give a result
  int                 settings_run;
  int                 idle_cycles;
  bit                 quiet;         // tail of the run, no idling on either side
  bit                 gaps_on;

  nearest_palette_color_search_core #(
    .PALETTE_DEPTH(DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_index (match_index)
  );

  nearest_palette_color_search_checker #(
    .PALETTE_DEPTH(DEPTH)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .entry_index     (entry_index),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .match_index     (match_index),
    .mismatches      (mismatches),
    .awaited         (awaited),
    .lookups_checked (lookups_checked),
    .writes_seen     (writes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: any transfer or register write counts as progress
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles, giving up", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure: random stall bursts between free stretches,
  // some of them long, and none once the run goes quiet
  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(40, 200)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // component values lean on the extremes and on a tiny set so that equal
  // colors and equal distances (ties) show up often
  function automatic logic [COMP_W-1:0] pick_component();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) return COMP_W'($urandom_range(0, 65535));
    if (m == 6) return '0;
    if (m == 7) return '1;
    return COMP_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    return {pick_component(), pick_component(), pick_component()};
  endfunction

  // small random offset around a component, clamped to its range
  function automatic logic [COMP_W-1:0] nudge(logic [COMP_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 64)) - 32;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return COMP_W'(v);
  endfunction

  function automatic logic [COLOR_W-1:0] nudge_color(logic [COLOR_W-1:0] c);
    return {nudge(c[47:32]), nudge(c[31:16]), nudge(c[15:0])};
  endfunction

  // one request transfer; valid stays high across back-to-back items and only
  // drops for an idle burst or a drain, the payload holds while the block stalls
  task automatic send_request(logic rt, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] rgb);
    if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rt;
    entry_index <= idx;
    red         <= rgb[47:32];
    green       <= rgb[31:16];
    blue        <= rgb[15:0];
    do @(posedge clk); while (in_stall);
  endtask

  // writes outside 1..span are dropped by the block and leave no trace here
  task automatic write_entry(logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] rgb);
    send_request(nps_pkg::REQ_WRITE, idx, rgb);
    if (idx >= 1 && idx <= span) begin
      tone[idx]    = rgb;
      painted[idx] = 1'b1;
      items_sent++;
    end
  endtask

  task automatic lookup(logic [COLOR_W-1:0] rgb);
    send_request(nps_pkg::REQ_LOOKUP, INDEX_W'($urandom_range(0, 511)), rgb);
    items_sent++;
  endtask

  // stop sending, wait for every outstanding match, then let a lookup-sized
  // stretch pass so that a trailing write has surely landed
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (span + 10) @(posedge clk);
  endtask

  // entry count only changes with the block idle; counts above the depth
  // behave as the depth
  task automatic set_entry_count(logic [INDEX_W-1:0] value);
    drain_block();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    span = (value > DEPTH) ? DEPTH : int'(value);
    settings_run++;
  endtask

  // every entry in use must hold a color before any lookup reads it
  task automatic paint_unwritten();
    for (int i = 1; i <= span; i++) begin
      if (!painted[i]) write_entry(INDEX_W'(i), pick_color());
    end
  endtask

  // lookups aimed at the palette: exact hits, near misses, corners and
  // midpoints between two entries, plus plain random colors
  task automatic random_lookup();
    logic [COLOR_W-1:0] a;
    logic [COLOR_W-1:0] b;
    int                 m;
    m = $urandom_range(0, 9);
    if (span == 0 || m < 3) begin
      lookup(pick_color());
    end else begin
      a = tone[$urandom_range(1, span)];
      b = tone[$urandom_range(1, span)];
      case (m)
        3, 4, 5: begin
          lookup(nudge_color(a));
        end
        6: begin
          lookup(a);
        end
        7: begin
          lookup({$urandom_range(0, 1) ? 16'hffff : 16'h0000,
                  $urandom_range(0, 1) ? 16'hffff : 16'h0000,
                  $urandom_range(0, 1) ? 16'hffff : 16'h0000});
        end
        default: begin
          lookup({COMP_W'((a[47:32] + 17'(b[47:32])) >> 1),
                  COMP_W'((a[31:16] + 17'(b[31:16])) >> 1),
                  COMP_W'((a[15:0] + 17'(b[15:0])) >> 1)});
        end
      endcase
    end
  endtask

  // in-range writes: fresh colors, copies of another entry (ties) or a
  // color close to another entry
  task automatic random_write();
    logic [COLOR_W-1:0] other;
    int                 m;
    other = tone[$urandom_range(1, span)];
    m     = $urandom_range(0, 9);
    if (m < 4) begin
      write_entry(INDEX_W'($urandom_range(1, span)), pick_color());
    end else if (m < 7) begin
      write_entry(INDEX_W'($urandom_range(1, span)), other);
    end else begin
      write_entry(INDEX_W'($urandom_range(1, span)), nudge_color(other));
    end
  endtask

  // writes the block must drop: position 0 or above the entry count
  task automatic stray_write();
    if (span == 511 || $urandom_range(0, 2) == 0) begin
      write_entry('0, pick_color());
    end else begin
      write_entry(INDEX_W'($urandom_range(span + 1, 511)), pick_color());
    end
  endtask

  initial begin
    int       phase;
    int       phase_items;
    int       k;
    logic [INDEX_W-1:0] next_count;

    // every input known from time zero
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    req_type    <= nps_pkg::REQ_WRITE;
    entry_index <= '0;
    red         <= '0;
    green       <= '0;
    blue        <= '0;
    span         = 1;
    items_sent   = 0;
    settings_run = 0;
    quiet        = 1'b0;
    gaps_on      = 1'b1;
    for (int i = 1; i <= DEPTH; i++) painted[i] = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ------------------------------------------------
    // reset count of one: the only entry always wins
    write_entry(9'd1, 48'h0000_0000_0000);
    lookup(48'hffff_ffff_ffff);
    // dropped writes: position 0, just above the count, top of the index range
    write_entry(9'd0, 48'h1234_5678_9abc);
    write_entry(9'd2, 48'hffff_ffff_ffff);
    write_entry(9'd511, 48'hffff_ffff_ffff);
    lookup(48'h0000_0000_0000);

    // four entries with a duplicate of entry 1 at entry 3, so ties go low
    set_entry_count(9'd4);
    write_entry(9'd2, 48'hffff_ffff_ffff);
    write_entry(9'd3, 48'h0000_0000_0000);
    write_entry(9'd4, 48'hffff_0000_ffff);
    lookup(48'h0000_0000_0000);
    lookup(48'hffff_ffff_ffff);
    lookup(48'hffff_0000_ffff);
    lookup(48'h0001_0001_0001);
    lookup(48'h8000_8000_8000);
    lookup(48'h7fff_7fff_7fff);
    // write one past the count is dropped, entry 4 stays the answer
    write_entry(9'd5, 48'hffff_0000_ffff);
    lookup(48'hfff0_0000_fff0);

    // zero count: nothing is visited, every write dropped, answer is 1
    set_entry_count(9'd0);
    write_entry(9'd1, 48'hffff_ffff_ffff);
    lookup(48'hffff_ffff_ffff);
    lookup(48'h0000_0000_0000);

    // ---- random phases ------------------------------------------------
    // the first settings cover the full palette, saturation and tiny counts;
    // later ones are mostly small so lookups stay short
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       next_count = 9'd256;
        1:       next_count = 9'd511;
        2:       next_count = 9'd0;
        3:       next_count = 9'd300;
        4:       next_count = 9'd2;
        5:       next_count = 9'd1;
        default: begin
          k = $urandom_range(0, 9);
          if (k == 0) next_count = 9'd0;
          else if (k == 1) next_count = INDEX_W'($urandom_range(25, 511));
          else next_count = INDEX_W'($urandom_range(1, 24));
        end
      endcase
      set_entry_count(next_count);
      paint_unwritten();
      phase_items = (span >= 64) ? $urandom_range(20, 40) : $urandom_range(40, 90);

      for (int n = 0; n < phase_items && items_sent < ITEM_TARGET; n++) begin
        // idle stretches on and off, then none at all near the end
        if ($urandom_range(0, 29) == 0) gaps_on = !gaps_on;
        if (items_sent >= ITEM_TARGET - 150) quiet = 1'b1;
        // now and then hold off until every match is back
        if (!quiet && $urandom_range(0, 49) == 0) drain_block();
        k = $urandom_range(0, 99);
        if (k < 55 || span == 0 && k < 90) begin
          random_lookup();
        end else if (k < 90) begin
          random_write();
        end else begin
          stray_write();
        end
      end
      phase++;
    end

    // ---- wind down ----------------------------------------------------
    quiet = 1'b1;
    drain_block();

    $display("covered %0d write transfers and %0d checked lookups over %0d entry count settings",
             writes_seen, lookups_checked, settings_run);
    $display("entry counts included zero, one, the full palette and saturated values");
    if (mismatches == 0 && awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
